// ===== rtl/pid_pkg.sv =====
// Shared constants, register index codes and types for the PID step block.
`timescale 1ns / 1ps

package pid_pkg;

   // Default data format: signed Q8.8
   localparam int DATA_WIDTH_DEF = 16;
   localparam int FRAC_BITS_DEF  = 8;

   // Control register index
   localparam int CSR_IDX_W = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_PROP      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_INTEG     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_DERIV     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_OUT_LOW_LIMIT  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_OUT_HIGH_LIMIT = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_PROP_ON_ERROR  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_AUTO_MODE      = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_REVERSE_DIR    = 3'd7;

   // Request action codes
   localparam logic ACTION_COMPUTE = 1'b0;
   localparam logic ACTION_INIT    = 1'b1;

   // Mode bits handed from the register file to the datapath
   typedef struct packed {
      logic prop_on_error;
      logic auto_mode;
      logic reverse_direction;
   } cfg_flags_type;

endpackage

// ===== rtl/pid_csr.sv =====
// Control register file: gains, output limits and mode bits.
`timescale 1ns / 1ps

module pid_csr
   import pid_pkg::*;
#(
   parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_write_en,
   input  logic [CSR_IDX_W-1:0]         csr_index,
   input  logic [DATA_WIDTH-1:0]        csr_write_data,
   output logic signed [DATA_WIDTH-1:0] gain_prop,
   output logic signed [DATA_WIDTH-1:0] gain_integ,
   output logic signed [DATA_WIDTH-1:0] gain_deriv,
   output logic signed [DATA_WIDTH-1:0] out_low_limit,
   output logic signed [DATA_WIDTH-1:0] out_high_limit,
   output cfg_flags_type                flags
);

   localparam logic [DATA_WIDTH-1:0] LIMIT_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};
   localparam logic [DATA_WIDTH-1:0] LIMIT_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};

   logic [DATA_WIDTH-1:0] gain_prop_ff, gain_integ_ff, gain_deriv_ff;
   logic [DATA_WIDTH-1:0] low_limit_ff, high_limit_ff;
   cfg_flags_type         flags_ff;

   // Register writes; every index value selects one register
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_prop_ff  <= '0;
         gain_integ_ff <= '0;
         gain_deriv_ff <= '0;
         low_limit_ff  <= LIMIT_MIN;
         high_limit_ff <= LIMIT_MAX;
         flags_ff.prop_on_error     <= 1'b1;
         flags_ff.auto_mode         <= 1'b0;
         flags_ff.reverse_direction <= 1'b0;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_GAIN_PROP:      gain_prop_ff  <= csr_write_data;
            CSR_GAIN_INTEG:     gain_integ_ff <= csr_write_data;
            CSR_GAIN_DERIV:     gain_deriv_ff <= csr_write_data;
            CSR_OUT_LOW_LIMIT:  low_limit_ff  <= csr_write_data;
            CSR_OUT_HIGH_LIMIT: high_limit_ff <= csr_write_data;
            CSR_PROP_ON_ERROR:  flags_ff.prop_on_error     <= csr_write_data[0];
            CSR_AUTO_MODE:      flags_ff.auto_mode         <= csr_write_data[0];
            CSR_REVERSE_DIR:    flags_ff.reverse_direction <= csr_write_data[0];
            default: begin
            end
         endcase
      end
   end

   assign gain_prop      = gain_prop_ff;
   assign gain_integ     = gain_integ_ff;
   assign gain_deriv     = gain_deriv_ff;
   assign out_low_limit  = low_limit_ff;
   assign out_high_limit = high_limit_ff;
   assign flags          = flags_ff;

endmodule

// ===== rtl/pid_datapath.sv =====
// Single-pass PID arithmetic: error, rounded products, integral clamp, output clamp.
`timescale 1ns / 1ps

module pid_datapath
   import pid_pkg::*;
#(
   parameter int DATA_WIDTH = DATA_WIDTH_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
   input  logic                         action,
   input  logic signed [DATA_WIDTH-1:0] measurement,
   input  logic signed [DATA_WIDTH-1:0] target,
   input  logic signed [DATA_WIDTH-1:0] initial_output,
   input  logic signed [DATA_WIDTH-1:0] integral_sum,
   input  logic signed [DATA_WIDTH-1:0] previous_measurement,
   input  logic signed [DATA_WIDTH-1:0] gain_prop,
   input  logic signed [DATA_WIDTH-1:0] gain_integ,
   input  logic signed [DATA_WIDTH-1:0] gain_deriv,
   input  logic signed [DATA_WIDTH-1:0] out_low_limit,
   input  logic signed [DATA_WIDTH-1:0] out_high_limit,
   input  cfg_flags_type                flags,
   output logic                         state_we,
   output logic signed [DATA_WIDTH-1:0] integral_next,
   output logic signed [DATA_WIDTH-1:0] previous_next,
   output logic signed [DATA_WIDTH-1:0] drive_value,
   output logic                         computed
);

   // EW: negated gain / raw difference, PW: full product, SW: sums of three terms
   localparam int EW     = DATA_WIDTH + 1;
   localparam int PW     = 2 * DATA_WIDTH + 2;
   localparam int SW     = DATA_WIDTH + 2;
   localparam int HALF_I = (1 << FRAC_BITS) >> 1;

   localparam logic signed [PW-1:0] SAT_MAX = {{(PW-DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}};
   localparam logic signed [PW-1:0] SAT_MIN = ~SAT_MAX;
   localparam logic signed [PW-1:0] HALF    = PW'(HALF_I);

   // Saturate to the data width
   function automatic logic signed [DATA_WIDTH-1:0] sat_w(input logic signed [PW-1:0] v);
      if (v > SAT_MAX) begin
         sat_w = DATA_WIDTH'(SAT_MAX);
      end else if (v < SAT_MIN) begin
         sat_w = DATA_WIDTH'(SAT_MIN);
      end else begin
         sat_w = DATA_WIDTH'(v);
      end
   endfunction

   // Gain times value, rounded half up to FRAC_BITS, then saturated
   function automatic logic signed [DATA_WIDTH-1:0] mul_q(input logic signed [EW-1:0] g,
                                                          input logic signed [DATA_WIDTH-1:0] v);
      logic signed [PW-1:0] prod;
      prod = PW'(g) * PW'(v);
      mul_q = sat_w((prod + HALF) >>> FRAC_BITS);
   endfunction

   // High limit checked first; crossed limits give hi above hi, else lo
   function automatic logic signed [DATA_WIDTH-1:0] clamp_lim(input logic signed [SW-1:0] v,
                                                              input logic signed [DATA_WIDTH-1:0] lo,
                                                              input logic signed [DATA_WIDTH-1:0] hi);
      if (v > SW'(hi)) begin
         clamp_lim = hi;
      end else if (v < SW'(lo)) begin
         clamp_lim = lo;
      end else begin
         clamp_lim = DATA_WIDTH'(v);
      end
   endfunction

   logic signed [EW-1:0]         kp_e, ki_e, kd_e;
   logic signed [EW-1:0]         err_raw, din_raw;
   logic signed [DATA_WIDTH-1:0] err, din;
   logic signed [DATA_WIDTH-1:0] p_term, i_term, d_term;
   logic signed [SW-1:0]         sum_raw, out_raw;
   logic signed [DATA_WIDTH-1:0] integ_auto;

   // Effective gains, negated at full precision in reverse direction
   always_comb begin
      kp_e = EW'(gain_prop);
      ki_e = EW'(gain_integ);
      kd_e = EW'(gain_deriv);
      if (flags.reverse_direction) begin
         kp_e = -kp_e;
         ki_e = -ki_e;
         kd_e = -kd_e;
      end
   end

   // Error and input change, saturated
   assign err_raw = EW'(target) - EW'(measurement);
   assign din_raw = EW'(measurement) - EW'(previous_measurement);
   assign err     = sat_w(PW'(err_raw));
   assign din     = sat_w(PW'(din_raw));

   // Proportional term acts on error or on input change, never both
   assign p_term = mul_q(kp_e, flags.prop_on_error ? err : din);
   assign i_term = mul_q(ki_e, err);
   assign d_term = mul_q(kd_e, din);

   // Integral update with anti-windup clamp
   assign sum_raw = SW'(integral_sum) + SW'(i_term)
                  - (flags.prop_on_error ? SW'(0) : SW'(p_term));
   assign integ_auto = clamp_lim(sum_raw, out_low_limit, out_high_limit);

   // Output sum and clamp
   assign out_raw = (flags.prop_on_error ? SW'(p_term) : SW'(0))
                  + SW'(integ_auto) - SW'(d_term);

   // Select by action and mode
   always_comb begin
      state_we      = 1'b0;
      integral_next = integ_auto;
      previous_next = measurement;
      drive_value   = '0;
      computed      = 1'b0;
      if (action == ACTION_INIT) begin
         state_we      = 1'b1;
         integral_next = clamp_lim(SW'(initial_output), out_low_limit, out_high_limit);
      end else if (flags.auto_mode) begin
         state_we    = 1'b1;
         drive_value = clamp_lim(out_raw, out_low_limit, out_high_limit);
         computed    = 1'b1;
      end
   end

endmodule

// ===== rtl/pid_controller_step.sv =====
// Top level of the PID step block: request register, datapath, state and result register.
`timescale 1ns / 1ps

// One PID sample per request, signed fixed point (Q8.8 by default). A request
// is captured in an input register; the datapath computes the new integral
// sum and output from that register and the stored state, and writes the
// result register once it is free. The block takes one request every cycle
// while the result side keeps up. On a state write the integral sum and last
// measurement are updated in the same cycle as the result register, so
// consecutive requests see each other's state with no gap. The user must write
// gains, limits and mode bits through the csr_ port only while no request is
// outstanding; the block does not enforce this. They take effect on the next request.

module pid_controller_step
   import pid_pkg::*;
#(
   parameter int DATA_WIDTH = DATA_WIDTH_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   // Request channel
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_action,
   input  logic signed [DATA_WIDTH-1:0] req_measurement,
   input  logic signed [DATA_WIDTH-1:0] req_target,
   input  logic signed [DATA_WIDTH-1:0] req_initial_output,
   // Result channel
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [DATA_WIDTH-1:0] rsp_drive_value,
   output logic                         rsp_computed,
   // Control registers
   input  logic                         csr_write_en,
   input  logic [CSR_IDX_W-1:0]         csr_index,
   input  logic [DATA_WIDTH-1:0]        csr_write_data
);

   logic signed [DATA_WIDTH-1:0] gain_prop, gain_integ, gain_deriv;
   logic signed [DATA_WIDTH-1:0] out_low_limit, out_high_limit;
   cfg_flags_type                flags;

   // Request register
   logic                         s1_valid_ff, s1_valid_in;
   logic                         s1_action_ff;
   logic signed [DATA_WIDTH-1:0] s1_meas_ff, s1_target_ff, s1_init_ff;

   // Controller state
   logic signed [DATA_WIDTH-1:0] integral_ff, previous_ff;

   // Result register
   logic                         rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_WIDTH-1:0] rsp_drive_ff;
   logic                         rsp_computed_ff;

   logic                         state_we, computed;
   logic signed [DATA_WIDTH-1:0] integral_next, previous_next, drive_value;
   logic                         req_fire, s1_fire, rsp_free;

   pid_csr #(
      .DATA_WIDTH(DATA_WIDTH)
   ) u_csr (
      .clock         (clock),
      .reset         (reset),
      .csr_write_en  (csr_write_en),
      .csr_index     (csr_index),
      .csr_write_data(csr_write_data),
      .gain_prop     (gain_prop),
      .gain_integ    (gain_integ),
      .gain_deriv    (gain_deriv),
      .out_low_limit (out_low_limit),
      .out_high_limit(out_high_limit),
      .flags         (flags)
   );

   pid_datapath #(
      .DATA_WIDTH(DATA_WIDTH),
      .FRAC_BITS (FRAC_BITS)
   ) u_datapath (
      .action              (s1_action_ff),
      .measurement         (s1_meas_ff),
      .target              (s1_target_ff),
      .initial_output      (s1_init_ff),
      .integral_sum        (integral_ff),
      .previous_measurement(previous_ff),
      .gain_prop           (gain_prop),
      .gain_integ          (gain_integ),
      .gain_deriv          (gain_deriv),
      .out_low_limit       (out_low_limit),
      .out_high_limit      (out_high_limit),
      .flags               (flags),
      .state_we            (state_we),
      .integral_next       (integral_next),
      .previous_next       (previous_next),
      .drive_value         (drive_value),
      .computed            (computed)
   );

   // Flow control: the request stage moves when the result register is free
   assign rsp_free     = !rsp_valid_ff || !rsp_stall;
   assign s1_fire      = s1_valid_ff && rsp_free;
   assign req_stall    = s1_valid_ff && !rsp_free;
   assign req_fire     = req_valid && !req_stall;
   assign s1_valid_in  = req_fire || (s1_valid_ff && !s1_fire);
   assign rsp_valid_in = s1_fire || (rsp_valid_ff && rsp_stall);

   // Control flags
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Request payload capture
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_action_ff <= req_action;
         s1_meas_ff   <= req_measurement;
         s1_target_ff <= req_target;
         s1_init_ff   <= req_initial_output;
      end
   end

   // Integral sum and last measurement
   always_ff @(posedge clock) begin
      if (reset) begin
         integral_ff <= '0;
         previous_ff <= '0;
      end else if (s1_fire && state_we) begin
         integral_ff <= integral_next;
         previous_ff <= previous_next;
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      if (s1_fire) begin
         rsp_drive_ff    <= drive_value;
         rsp_computed_ff <= computed;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_drive_value = rsp_drive_ff;
   assign rsp_computed    = rsp_computed_ff;

`ifndef SYNTH
   // State only moves when a request leaves the input register
   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !s1_fire |=> ($stable(integral_ff) && $stable(previous_ff)))
      else $error("controller state changed without a request");

   // A held request stays in the input register
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_fire) |=> s1_valid_ff)
      else $error("request lost from input register");

   // Manual and initialize results carry a zero output
   a_zero_drive: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_computed_ff) |-> (rsp_drive_ff == '0))
      else $error("nonzero output on a result that was not computed");
`endif

endmodule
